>>> hdl/ckrb_pkg.sv
package ckrb_pkg;

	localparam int ADDR_BITS  = 24;
	localparam int COORD_BITS = 12;
	localparam int PROD_BITS  = 2 * COORD_BITS + 1;
	localparam int KEY_BITS   = 8;
	localparam int TBL_DEPTH  = 2 ** KEY_BITS;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);

	localparam logic ACT_TABLE = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef enum logic [2:0] {
		REG_PITCH  = 3'd0,
		REG_DEST_X = 3'd1,
		REG_DEST_Y = 3'd2,
		REG_SRC_X1 = 3'd3,
		REG_SRC_Y1 = 3'd4,
		REG_SRC_X2 = 3'd5,
		REG_SRC_Y2 = 3'd6,
		REG_KEY    = 3'd7
	} cfg_reg_t;

	// one classified pixel, front to back
	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic                  start;
		logic                  row_adv;
		logic                  last;
		logic                  wr;
		logic [KEY_BITS-1:0]   color;
		logic [COORD_BITS:0]   ysum;
		logic [COORD_BITS:0]   xsum;
		logic [COORD_BITS-1:0] pitch;
	} rec_t;

endpackage

>>> hdl/ckrb_front.sv
module ckrb_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           action,
	input  logic [ckrb_pkg::KEY_BITS-1:0]  table_index,
	input  logic [ckrb_pkg::KEY_BITS-1:0]  table_value,
	input  logic [ckrb_pkg::KEY_BITS-1:0]  pixel,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [ckrb_pkg::COORD_BITS-1:0] cfg_data,
	input  logic                           q_full,
	output logic                           push,
	output ckrb_pkg::rec_t                 rec
);

	logic [ckrb_pkg::COORD_BITS-1:0] pitch_q, dest_x_q, dest_y_q;
	logic [ckrb_pkg::COORD_BITS-1:0] src_x1_q, src_y1_q, src_x2_q, src_y2_q;
	logic [ckrb_pkg::KEY_BITS-1:0]   key_q;
	logic [ckrb_pkg::COORD_BITS-1:0] col_q, row_q;
	logic [ckrb_pkg::COORD_BITS-1:0] col_end, row_end;
	logic                            at_col, at_row;
	logic                            accept, pix_acc, tab_acc;

	logic [ckrb_pkg::KEY_BITS-1:0] tbl_q [ckrb_pkg::TBL_DEPTH];
	logic [ckrb_pkg::TBL_DEPTH-1:0] tvld_q;

	logic                          v_s1;
	ckrb_pkg::rec_t                rec_s1;
	logic [ckrb_pkg::KEY_BITS-1:0] rdat_s1;
	logic                          rvld_s1;

	always_comb begin
		item_stall = v_s1 & q_full;
		accept     = item_valid & ~item_stall;
		pix_acc    = accept & (action == ckrb_pkg::ACT_PIXEL);
		tab_acc    = accept & (action == ckrb_pkg::ACT_TABLE);
		col_end    = src_x2_q - src_x1_q;
		row_end    = src_y2_q - src_y1_q;
		at_col     = (col_q == col_end);
		at_row     = (row_q == row_end);
		push       = v_s1;
		rec        = rec_s1;
		rec.color  = rvld_s1 ? rdat_s1 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q  <= ckrb_pkg::COORD_BITS'(1);
			dest_x_q <= '0;
			dest_y_q <= '0;
			src_x1_q <= '0;
			src_y1_q <= '0;
			src_x2_q <= '0;
			src_y2_q <= '0;
			key_q    <= '0;
		end else if (cfg_we) begin
			unique case (ckrb_pkg::cfg_reg_t'(cfg_index))
				ckrb_pkg::REG_PITCH:  pitch_q  <= cfg_data;
				ckrb_pkg::REG_DEST_X: dest_x_q <= cfg_data;
				ckrb_pkg::REG_DEST_Y: dest_y_q <= cfg_data;
				ckrb_pkg::REG_SRC_X1: src_x1_q <= cfg_data;
				ckrb_pkg::REG_SRC_Y1: src_y1_q <= cfg_data;
				ckrb_pkg::REG_SRC_X2: src_x2_q <= cfg_data;
				ckrb_pkg::REG_SRC_Y2: src_y2_q <= cfg_data;
				ckrb_pkg::REG_KEY:    key_q    <= cfg_data[ckrb_pkg::KEY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			v_s1   <= 1'b0;
			tvld_q <= '0;
		end else begin
			if (tab_acc) begin
				tvld_q[table_index] <= 1'b1;
			end
			if (pix_acc) begin
				v_s1 <= 1'b1;
				if (at_col) begin
					col_q <= '0;
					row_q <= at_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (!q_full) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tab_acc) begin
			tbl_q[table_index] <= table_value;
		end
		if (pix_acc) begin
			rdat_s1        <= tbl_q[pixel];
			rvld_s1        <= tvld_q[pixel];
			rec_s1.col     <= col_q;
			rec_s1.start   <= (col_q == '0) && (row_q == '0);
			rec_s1.row_adv <= at_col & ~at_row;
			rec_s1.last    <= at_col & at_row;
			rec_s1.wr      <= (pixel != key_q);
			rec_s1.color   <= '0;
			rec_s1.ysum    <= {1'b0, dest_y_q} + {1'b0, src_y1_q};
			rec_s1.xsum    <= {1'b0, dest_x_q} + {1'b0, src_x1_q};
			rec_s1.pitch   <= pitch_q;
		end
	end

endmodule

>>> hdl/ckrb_fifo.sv
module ckrb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  ckrb_pkg::rec_t rec_in,
	input  logic           pop,
	output logic           not_empty,
	output ckrb_pkg::rec_t rec_out
);

	ckrb_pkg::rec_t                 mem_q [ckrb_pkg::QDEPTH];
	logic [ckrb_pkg::QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [ckrb_pkg::QPTR_BITS:0]   cnt_q;
	logic                           wr_en, rd_en;

	always_comb begin
		full      = (cnt_q == (ckrb_pkg::QPTR_BITS+1)'(ckrb_pkg::QDEPTH));
		not_empty = (cnt_q != '0);
		wr_en     = push & ~full;
		rd_en     = pop & not_empty;
		rec_out   = mem_q[rptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en & ~rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en & ~wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= rec_in;
		end
	end

endmodule

>>> hdl/ckrb_back.sv
module ckrb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  ckrb_pkg::rec_t                 q_rec,
	output logic                           pop,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [ckrb_pkg::ADDR_BITS-1:0] dest_address,
	output logic [ckrb_pkg::KEY_BITS-1:0]  color,
	output logic                           write,
	output logic                           last
);

	logic                           v_s2, v_s3, v_s4, out_v_q;
	ckrb_pkg::rec_t                 rec_s2, rec_s3, rec_s4;
	logic [ckrb_pkg::PROD_BITS-1:0] prod_s3;
	logic [ckrb_pkg::ADDR_BITS-1:0] sbase_s4;
	logic [ckrb_pkg::ADDR_BITS-1:0] row_base_q, base;
	logic [ckrb_pkg::ADDR_BITS-1:0] addr_q;
	logic [ckrb_pkg::KEY_BITS-1:0]  color_q;
	logic                           write_q, last_q;
	logic                           en_o, en4, en3, en2;

	always_comb begin
		en_o = ~out_v_q | ~result_stall;
		en4  = ~v_s4 | en_o;
		en3  = ~v_s3 | en4;
		en2  = ~v_s2 | en3;
		pop  = q_valid & en2;
		base = rec_s4.start ? sbase_s4 : row_base_q;
		result_valid = out_v_q;
		dest_address = addr_q;
		color        = color_q;
		write        = write_q;
		last         = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			out_v_q    <= 1'b0;
			row_base_q <= '0;
		end else begin
			if (en2) v_s2 <= q_valid;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en_o) begin
				out_v_q <= v_s4;
				if (v_s4) begin
					row_base_q <= rec_s4.row_adv ?
						base + ckrb_pkg::ADDR_BITS'(rec_s4.pitch) : base;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			rec_s2 <= q_rec;
		end
		if (en3) begin
			rec_s3  <= rec_s2;
			prod_s3 <= ckrb_pkg::PROD_BITS'(rec_s2.ysum) *
				ckrb_pkg::PROD_BITS'(rec_s2.pitch);
		end
		if (en4) begin
			rec_s4   <= rec_s3;
			sbase_s4 <= ckrb_pkg::ADDR_BITS'(prod_s3) +
				ckrb_pkg::ADDR_BITS'(rec_s3.xsum);
		end
		if (en_o && v_s4) begin
			addr_q  <= base + ckrb_pkg::ADDR_BITS'(rec_s4.col);
			color_q <= rec_s4.color;
			write_q <= rec_s4.wr;
			last_q  <= rec_s4.last;
		end
	end

endmodule

>>> hdl/color_keyed_remap_blit.sv
// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------------
// item     | item_valid / item_stall     | action, table_index, table_value, pixel
// result   | result_valid / result_stall | dest_address, color, write, last
// config   | cfg_we                      | cfg_index, cfg_data
//
// One item per clock while item_stall is low. A pixel beat that is taken reaches
// the result side by way of the remap read, the queue, the multiply and the two
// address adds. Table beats make no result.
// Reset: the remap table reads zero until an entry is loaded (per-entry valid bits).
// item_stall rises only when the four-deep queue is full and the front stage holds.
module color_keyed_remap_blit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            action,
	input  logic [ckrb_pkg::KEY_BITS-1:0]   table_index,
	input  logic [ckrb_pkg::KEY_BITS-1:0]   table_value,
	input  logic [ckrb_pkg::KEY_BITS-1:0]   pixel,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [ckrb_pkg::ADDR_BITS-1:0]  dest_address,
	output logic [ckrb_pkg::KEY_BITS-1:0]   color,
	output logic                            write,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [ckrb_pkg::COORD_BITS-1:0] cfg_data
);

	logic           q_full, push, q_valid, pop;
	ckrb_pkg::rec_t rec_in, rec_out;

	ckrb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.table_index (table_index),
		.table_value (table_value),
		.pixel       (pixel),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.push        (push),
		.rec         (rec_in)
	);

	ckrb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.rec_in    (rec_in),
		.pop       (pop),
		.not_empty (q_valid),
		.rec_out   (rec_out)
	);

	ckrb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_rec        (rec_out),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dest_address (dest_address),
		.color        (color),
		.write        (write),
		.last         (last)
	);

endmodule
